FILE: design/i2cebm_pkg.sv
// Package for the I2C EEPROM byte master: phase codes, register indexes,
// widths, reset values and the result record. No dependencies.
`timescale 1ns / 1ps

package i2cebm_pkg;

  localparam int DEV_ADDR_W = 7;
  localparam int WAIT_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int BYTE_W     = 8;

  localparam logic [DEV_ADDR_W-1:0] DEV_ADDR_RESET = 7'd80;
  localparam logic [WAIT_W-1:0]     WAIT_RESET     = 16'd1000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEVICE_ADDRESS   = 1'b0,
    CFG_WRITE_CYCLE_WAIT = 1'b1
  } cfg_index_t;

  // Which byte of the sequence is on the wire.
  typedef enum logic [1:0] {
    STEP_DEV_ADDR = 2'd0,
    STEP_MEM_ADDR = 2'd1,
    STEP_PAYLOAD  = 2'd2
  } byte_step_t;

  // Bus sequencer phases, one-hot.
  typedef enum logic [13:0] {
    PH_IDLE     = 14'h0001,
    PH_START_HI = 14'h0002,
    PH_START_LO = 14'h0004,
    PH_RESTART  = 14'h0008,
    PH_TX       = 14'h0010,
    PH_ACK_LO   = 14'h0020,
    PH_ACK_HI   = 14'h0040,
    PH_RX       = 14'h0080,
    PH_NACK_LO  = 14'h0100,
    PH_NACK_HI  = 14'h0200,
    PH_STOP_A   = 14'h0400,
    PH_STOP_B   = 14'h0800,
    PH_STOP_C   = 14'h1000,
    PH_WAIT     = 14'h2000
  } phase_t;

  // One result: line levels and status.
  typedef struct packed {
    logic              scl_level;
    logic              sda_level;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              nack_seen;
  } result_t;

endpackage

FILE: design/i2cebm_if.sv
// Request and result channel interfaces for the I2C EEPROM byte master.
// Depends on i2cebm_pkg for field widths.
`timescale 1ns / 1ps

interface i2cebm_req_if;
  logic                         valid;
  logic                         ready;
  logic                         start_request;
  logic                         mode;
  logic [i2cebm_pkg::BYTE_W-1:0] mem_address;
  logic [i2cebm_pkg::BYTE_W-1:0] write_data;
  logic                         sda_sample;

  modport source (output valid, start_request, mode, mem_address, write_data, sda_sample,
                  input ready);
  modport sink   (input valid, start_request, mode, mem_address, write_data, sda_sample,
                  output ready);
endinterface

interface i2cebm_res_if;
  logic                         valid;
  logic                         ready;
  logic                         scl_level;
  logic                         sda_level;
  logic                         busy_res;
  logic                         done_res;
  logic [i2cebm_pkg::BYTE_W-1:0] read_byte;
  logic                         nack_seen;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, read_byte, nack_seen,
                  input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_byte, nack_seen,
                  output ready);
endinterface

FILE: design/i2c_eeprom_byte_master.sv
// I2C EEPROM byte master: one request per bus tick, one result per request.
// Throughput: one request per cycle while the skid register is empty; a two-entry
// output stage (output and skid register) holds the registered results under stall.
// Reset (rst, synchronous, active high): sequencer idle, registers to their reset values,
// output stage empty. Depends on i2cebm_pkg and the channel interfaces in i2cebm_if.sv.
`timescale 1ns / 1ps

module i2c_eeprom_byte_master (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [i2cebm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [i2cebm_pkg::CFG_DATA_W-1:0]   cfg_data,
  i2cebm_req_if.sink                          request,
  i2cebm_res_if.source                        result
);
  import i2cebm_pkg::*;

  // Each request is one tick of the bus sequencer. The sequencer state advances
  // only when a request is taken, so stalls on either side never disturb the
  // bus timing as seen in the stream of results.

  // Configuration registers.
  logic [DEV_ADDR_W-1:0] device_address;
  logic [WAIT_W-1:0]     write_cycle_wait;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= DEV_ADDR_RESET;
      write_cycle_wait <= WAIT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DEVICE_ADDRESS:   device_address   <= cfg_data[DEV_ADDR_W-1:0];
        CFG_WRITE_CYCLE_WAIT: write_cycle_wait <= cfg_data[WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state.
  phase_t            phase, phase_next;
  logic [3:0]        bit_count, bit_count_next;
  logic [BYTE_W-1:0] shift_reg, shift_reg_next;
  byte_step_t        byte_step, byte_step_next;
  logic [WAIT_W-1:0] wait_count, wait_count_next;
  logic              req_mode, req_mode_next;
  logic [BYTE_W-1:0] req_addr, req_addr_next;
  logic [BYTE_W-1:0] req_data, req_data_next;
  logic [BYTE_W-1:0] received_byte, received_byte_next;
  logic              nack_flag, nack_flag_next;

  result_t res_new;
  logic    accept;

  // The whole tick is one pass: decode the phase, drive the lines, update state.
  always_comb begin
    logic [WAIT_W-1:0] wait_dec;

    wait_dec           = wait_count - 1'b1;
    phase_next         = phase;
    bit_count_next     = bit_count;
    shift_reg_next     = shift_reg;
    byte_step_next     = byte_step;
    wait_count_next    = wait_count;
    req_mode_next      = req_mode;
    req_addr_next      = req_addr;
    req_data_next      = req_data;
    received_byte_next = received_byte;
    nack_flag_next     = nack_flag;

    res_new.scl_level = 1'b1;
    res_new.sda_level = 1'b1;
    res_new.busy_res  = 1'b1;
    res_new.done_res  = 1'b0;

    unique case (phase)
      PH_START_HI: begin
        phase_next = PH_START_LO;
      end
      PH_START_LO: begin
        // Start condition completes; load the device address byte, with the
        // read bit set once the memory address has gone out.
        res_new.sda_level = 1'b0;
        shift_reg_next    = {device_address, (byte_step != STEP_DEV_ADDR)};
        bit_count_next    = 4'd0;
        phase_next        = PH_TX;
      end
      PH_RESTART: begin
        res_new.scl_level = 1'b0;
        phase_next        = PH_START_HI;
      end
      PH_TX: begin
        // Even count: clock low, data set up. Odd count: clock high, data held.
        res_new.scl_level = bit_count[0];
        res_new.sda_level = shift_reg[BYTE_W-1];
        if (bit_count[0]) begin
          shift_reg_next = {shift_reg[BYTE_W-2:0], 1'b0};
        end
        if (bit_count == 4'd15) begin
          bit_count_next = 4'd0;
          phase_next     = PH_ACK_LO;
        end else begin
          bit_count_next = bit_count + 4'd1;
        end
      end
      PH_ACK_LO: begin
        res_new.scl_level = 1'b0;
        phase_next        = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        // A high level on the ACK slot is a NACK; note it and carry on.
        if (request.sda_sample) begin
          nack_flag_next = 1'b1;
        end
        bit_count_next = 4'd0;
        case (byte_step)
          STEP_DEV_ADDR: begin
            byte_step_next = STEP_MEM_ADDR;
            shift_reg_next = req_addr;
            phase_next     = PH_TX;
          end
          STEP_MEM_ADDR: begin
            byte_step_next = STEP_PAYLOAD;
            if (req_mode) begin
              phase_next = PH_RESTART;
            end else begin
              shift_reg_next = req_data;
              phase_next     = PH_TX;
            end
          end
          default: begin
            phase_next     = req_mode ? PH_RX : PH_STOP_A;
            shift_reg_next = '0;
          end
        endcase
      end
      PH_RX: begin
        res_new.scl_level = bit_count[0];
        if (bit_count[0]) begin
          shift_reg_next = {shift_reg[BYTE_W-2:0], request.sda_sample};
        end
        if (bit_count == 4'd15) begin
          bit_count_next     = 4'd0;
          received_byte_next = shift_reg_next;
          phase_next         = PH_NACK_LO;
        end else begin
          bit_count_next = bit_count + 4'd1;
        end
      end
      PH_NACK_LO: begin
        res_new.scl_level = 1'b0;
        phase_next        = PH_NACK_HI;
      end
      PH_NACK_HI: begin
        phase_next = PH_STOP_A;
      end
      PH_STOP_A: begin
        res_new.scl_level = 1'b0;
        res_new.sda_level = 1'b0;
        phase_next        = PH_STOP_B;
      end
      PH_STOP_B: begin
        res_new.sda_level = 1'b0;
        phase_next        = PH_STOP_C;
      end
      PH_STOP_C: begin
        // After a write with a non-zero wait the device programs; stay busy meanwhile.
        if (!req_mode && (write_cycle_wait != '0)) begin
          wait_count_next = write_cycle_wait;
          phase_next      = PH_WAIT;
        end else begin
          res_new.done_res = 1'b1;
          phase_next       = PH_IDLE;
        end
      end
      PH_WAIT: begin
        wait_count_next = wait_dec;
        if (wait_dec == '0) begin
          res_new.done_res = 1'b1;
          phase_next       = PH_IDLE;
        end
      end
      default: begin
        // Idle: a start request is latched and the sequence begins.
        phase_next = PH_IDLE;
        if (request.start_request) begin
          req_mode_next  = request.mode;
          req_addr_next  = request.mem_address;
          req_data_next  = request.write_data;
          nack_flag_next = 1'b0;
          byte_step_next = STEP_DEV_ADDR;
          bit_count_next = 4'd0;
          phase_next     = PH_START_HI;
        end else begin
          res_new.busy_res = 1'b0;
        end
      end
    endcase

    res_new.read_byte = received_byte_next;
    res_new.nack_seen = nack_flag_next;
  end

  // Output stage: a main register and a skid register. The request side is
  // ready whenever the skid register is empty, so it never waits on the
  // result side combinationally.
  result_t out_data, skid_data;
  logic    out_valid, skid_valid;
  logic    load_out;

  assign request.ready = !skid_valid;
  assign accept        = request.valid && !skid_valid;
  assign load_out      = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_count     <= '0;
      shift_reg     <= '0;
      byte_step     <= STEP_DEV_ADDR;
      wait_count    <= '0;
      req_mode      <= 1'b0;
      req_addr      <= '0;
      req_data      <= '0;
      received_byte <= '0;
      nack_flag     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      shift_reg     <= shift_reg_next;
      byte_step     <= byte_step_next;
      wait_count    <= wait_count_next;
      req_mode      <= req_mode_next;
      req_addr      <= req_addr_next;
      req_data      <= req_data_next;
      received_byte <= received_byte_next;
      nack_flag     <= nack_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= res_new;
      end
    end else if (accept) begin
      skid_data <= res_new;
    end
  end

  assign result.valid     = out_valid;
  assign result.scl_level = out_data.scl_level;
  assign result.sda_level = out_data.sda_level;
  assign result.busy_res  = out_data.busy_res;
  assign result.done_res  = out_data.done_res;
  assign result.read_byte = out_data.read_byte;
  assign result.nack_seen = out_data.nack_seen;

endmodule

FILE: tb/tb_i2c_eeprom_byte_master.sv
// Self-checking testbench for the I2C EEPROM byte master: bus ticks go in as
// requests, line levels and status come back and are checked against a predictor.
// Depends on i2cebm_pkg, the channel interfaces and the i2c_eeprom_byte_master RTL.
`timescale 1ns / 1ps

module tb_i2c_eeprom_byte_master;
  import i2cebm_pkg::*;

  // One bus tick as the request channel carries it.
  typedef struct packed {
    logic              start;
    logic              mode;
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              sda;
  } bus_tick_t;

  // Read-mode and write-mode operation lengths in ticks after the request tick.
  // A write adds the programming wait on top of its fixed part.
  localparam int READ_SPAN  = 80;
  localparam int WRITE_SPAN = 59;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_write_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  i2cebm_req_if req_if();
  i2cebm_res_if res_if();

  i2c_eeprom_byte_master u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .request      (req_if),
    .result       (res_if)
  );

  always #10 clk = ~clk;

  // Ticks waiting to be sent, and the line levels and status they should produce.
  bus_tick_t pending_ticks[$];
  result_t   expected_levels[$];
  int        mismatch_count = 0;
  bit        idling_on = 1'b1;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;

  // Predictor copy of the configuration.
  logic [DEV_ADDR_W-1:0] dev_addr;
  logic [WAIT_W-1:0]     cfg_wait;

  // Predictor copy of the bus sequencer.
  phase_t            seq_phase;
  byte_step_t        seq_step;
  logic [3:0]        bit_idx;
  logic [BYTE_W-1:0] shift_q;
  logic [WAIT_W-1:0] wait_left;
  logic              held_read;
  logic [BYTE_W-1:0] held_addr;
  logic [BYTE_W-1:0] held_data;
  logic [BYTE_W-1:0] rx_byte;
  logic              nack_flag;

  // Advances the predicted sequencer by one tick and returns the levels and status
  // that the block should show for it. Read byte and NACK flag are the updated values.
  function automatic result_t advance_sequencer(input bus_tick_t t);
    result_t r;
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    r.busy_res  = 1'b1;
    r.done_res  = 1'b0;
    case (seq_phase)
      PH_START_HI: seq_phase = PH_START_LO;
      PH_START_LO: begin
        // The address byte carries the read bit only on the repeated start.
        r.sda_level = 1'b0;
        shift_q = {dev_addr, (seq_step != STEP_DEV_ADDR)};
        bit_idx = '0;
        seq_phase = PH_TX;
      end
      PH_RESTART: begin
        r.scl_level = 1'b0;
        seq_phase = PH_START_HI;
      end
      PH_TX: begin
        r.scl_level = bit_idx[0];
        r.sda_level = shift_q[7];
        if (bit_idx[0]) shift_q = shift_q << 1;
        if (bit_idx == 4'd15) begin
          bit_idx = '0;
          seq_phase = PH_ACK_LO;
        end else begin
          bit_idx = bit_idx + 4'd1;
        end
      end
      PH_ACK_LO: begin
        r.scl_level = 1'b0;
        seq_phase = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        // A high line in the acknowledge slot is a NACK; it is noted and ignored.
        if (t.sda) nack_flag = 1'b1;
        bit_idx = '0;
        case (seq_step)
          STEP_DEV_ADDR: begin
            seq_step = STEP_MEM_ADDR;
            shift_q = held_addr;
            seq_phase = PH_TX;
          end
          STEP_MEM_ADDR: begin
            seq_step = STEP_PAYLOAD;
            if (held_read) begin
              seq_phase = PH_RESTART;
            end else begin
              shift_q = held_data;
              seq_phase = PH_TX;
            end
          end
          default: begin
            if (held_read) seq_phase = PH_RX;
            else seq_phase = PH_STOP_A;
            shift_q = '0;
          end
        endcase
      end
      PH_RX: begin
        r.scl_level = bit_idx[0];
        if (bit_idx[0]) shift_q = {shift_q[6:0], t.sda};
        if (bit_idx == 4'd15) begin
          bit_idx = '0;
          rx_byte = shift_q;
          seq_phase = PH_NACK_LO;
        end else begin
          bit_idx = bit_idx + 4'd1;
        end
      end
      PH_NACK_LO: begin
        r.scl_level = 1'b0;
        seq_phase = PH_NACK_HI;
      end
      PH_NACK_HI: seq_phase = PH_STOP_A;
      PH_STOP_A: begin
        r.scl_level = 1'b0;
        r.sda_level = 1'b0;
        seq_phase = PH_STOP_B;
      end
      PH_STOP_B: begin
        r.sda_level = 1'b0;
        seq_phase = PH_STOP_C;
      end
      PH_STOP_C: begin
        // A write with a non-zero wait stays busy; otherwise this is the done tick.
        if (!held_read && cfg_wait != '0) begin
          wait_left = cfg_wait;
          seq_phase = PH_WAIT;
        end else begin
          r.done_res = 1'b1;
          seq_phase = PH_IDLE;
        end
      end
      PH_WAIT: begin
        wait_left = wait_left - 1'b1;
        if (wait_left == '0) begin
          r.done_res = 1'b1;
          seq_phase = PH_IDLE;
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        if (t.start) begin
          held_read = t.mode;
          held_addr = t.addr;
          held_data = t.data;
          nack_flag = 1'b0;
          seq_step = STEP_DEV_ADDR;
          bit_idx = '0;
          seq_phase = PH_START_HI;
        end else begin
          r.busy_res = 1'b0;
        end
      end
    endcase
    r.read_byte = rx_byte;
    r.nack_seen = nack_flag;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Sender: takes ticks from the pending queue, with random bursts of idling.
  // The prediction is made at the edge where the request is taken.
  always @(posedge clk) begin : send_proc
    bus_tick_t nxt;
    bus_tick_t taken;
    if (rst) begin
      req_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        taken = {req_if.start_request, req_if.mode, req_if.mem_address,
                 req_if.write_data, req_if.sda_sample};
        expected_levels.push_back(advance_sequencer(taken));
      end
      if (req_if.valid && !req_if.ready) begin
        // Request still on offer: hold it.
      end else if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (idling_on && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 12);
        req_if.valid <= 1'b0;
      end else if (pending_ticks.size() != 0) begin
        nxt = pending_ticks.pop_front();
        req_if.start_request <= nxt.start;
        req_if.mode          <= nxt.mode;
        req_if.mem_address   <= nxt.addr;
        req_if.write_data    <= nxt.data;
        req_if.sda_sample    <= nxt.sda;
        req_if.valid         <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, and a field by field check of every result taken.
  always @(posedge clk) begin : recv_proc
    result_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_levels.size() == 0) begin
          flag_mismatch("unexpected result", 8'd0, 8'd0);
        end else begin
          want = expected_levels.pop_front();
          if (res_if.scl_level !== want.scl_level)
            flag_mismatch("scl_level", 8'(res_if.scl_level), 8'(want.scl_level));
          if (res_if.sda_level !== want.sda_level)
            flag_mismatch("sda_level", 8'(res_if.sda_level), 8'(want.sda_level));
          if (res_if.busy_res !== want.busy_res)
            flag_mismatch("busy_res", 8'(res_if.busy_res), 8'(want.busy_res));
          if (res_if.done_res !== want.done_res)
            flag_mismatch("done_res", 8'(res_if.done_res), 8'(want.done_res));
          if (res_if.read_byte !== want.read_byte)
            flag_mismatch("read_byte", res_if.read_byte, want.read_byte);
          if (res_if.nack_seen !== want.nack_seen)
            flag_mismatch("nack_seen", 8'(res_if.nack_seen), 8'(want.nack_seen));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        res_if.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 15) == 0) begin
        recv_gap = $urandom_range(0, 12);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic queue_tick(input logic start, input logic mode, input logic [7:0] addr,
                            input logic [7:0] data, input logic sda);
    bus_tick_t t;
    t = {start, mode, addr, data, sda};
    pending_ticks.push_back(t);
  endtask

  // Line level seen by the block: held low, held high, random, or mostly low.
  function automatic logic pick_sda(input int style);
    case (style)
      0: return 1'b0;
      1: return 1'b1;
      2: return 1'($urandom_range(0, 1));
      default: return ($urandom_range(0, 7) == 0);
    endcase
  endfunction

  // One complete operation: the request tick, then enough ticks to carry it to its
  // done tick. Starts on those later ticks arrive while busy and must be ignored.
  task automatic queue_operation(input logic rd, input logic [7:0] addr, input logic [7:0] data,
                                 input int sda_style, input int busy_starts);
    int span;
    logic s;
    span = rd ? READ_SPAN : WRITE_SPAN + int'(cfg_wait);
    queue_tick(1'b1, rd, addr, data, pick_sda(sda_style));
    repeat (span) begin
      s = (busy_starts == 2) ? 1'($urandom_range(0, 1)) : 1'(busy_starts);
      queue_tick(s, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), pick_sda(sda_style));
    end
  endtask

  // Random ticks; roughly one in four carries a start, so a new operation follows
  // shortly after each done tick. The line behaviour changes every few dozen ticks
  // so that clean acknowledges and NACKs both get long runs.
  task automatic queue_random_traffic(input int count);
    int style;
    style = 2;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) style = $urandom_range(0, 3);
      queue_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), pick_sda(style));
    end
  endtask

  // Waits until every request has been taken and every result checked, and pads
  // with plain ticks until the sequencer is back in idle.
  task automatic settle_to_idle();
    bit settled;
    settled = 1'b0;
    while (!settled) begin
      @(negedge clk);
      if (pending_ticks.size() == 0 && !req_if.valid && expected_levels.size() == 0) begin
        if (seq_phase == PH_IDLE) settled = 1'b1;
        else queue_tick(1'b0, 1'b0, 8'd0, 8'd0, 1'b1);
      end
    end
  endtask

  // Writes both registers on consecutive edges. Upper data bits of the address write
  // are random and must be dropped by the block.
  task automatic program_registers(input logic [6:0] addr, input logic [15:0] wait_ticks);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_DEVICE_ADDRESS;
    cfg_data     <= {9'($urandom_range(0, 511)), addr};
    @(posedge clk);
    cfg_index    <= CFG_WRITE_CYCLE_WAIT;
    cfg_data     <= wait_ticks;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    dev_addr = addr;
    cfg_wait = wait_ticks;
    @(negedge clk);
  endtask

  initial begin
    req_if.valid         = 1'b0;
    req_if.start_request = 1'b0;
    req_if.mode          = 1'b0;
    req_if.mem_address   = '0;
    req_if.write_data    = '0;
    req_if.sda_sample    = 1'b1;
    res_if.ready         = 1'b0;
    cfg_write_en         = 1'b0;
    cfg_index            = CFG_DEVICE_ADDRESS;
    cfg_data             = '0;

    dev_addr  = DEV_ADDR_RESET;
    cfg_wait  = WAIT_RESET;
    seq_phase = PH_IDLE;
    seq_step  = STEP_DEV_ADDR;
    bit_idx   = '0;
    shift_q   = '0;
    wait_left = '0;
    held_read = 1'b0;
    held_addr = '0;
    held_data = '0;
    rx_byte   = '0;
    nack_flag = 1'b0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with the device address at its reset value. Idle ticks carry the
    // field extremes; the first read sees starts on every busy tick. Operations follow
    // one another back to back, so each request lands on the first idle tick.
    queue_tick(1'b0, 1'b1, 8'hFF, 8'hFF, 1'b1);
    queue_tick(1'b0, 1'b0, 8'h00, 8'h00, 1'b0);
    queue_operation(1'b1, 8'hFF, 8'h00, 0, 1);
    queue_operation(1'b1, 8'h00, 8'h00, 1, 0);   // every slot NACKed, byte reads as all ones
    queue_operation(1'b1, 8'hFF, 8'hFF, 0, 2);   // NACK flag clears at the request
    settle_to_idle();

    // Lowest settings: address zero and no programming wait, so the write's done
    // tick is its last stop tick.
    program_registers(7'd0, 16'd0);
    queue_operation(1'b0, 8'h3C, 8'hC3, 3, 2);
    queue_operation(1'b1, 8'h5A, 8'h00, 2, 2);
    queue_operation(1'b0, 8'hFF, 8'hFF, 0, 1);
    queue_operation(1'b0, 8'h00, 8'hFF, 1, 2);
    settle_to_idle();

    // Highest address and a longer programming wait, then a read.
    program_registers(7'd127, 16'd60);
    queue_operation(1'b0, 8'h81, 8'h7E, 2, 2);
    queue_operation(1'b1, 8'h7F, 8'h00, 0, 2);
    settle_to_idle();

    // Random traffic under several settings; the last phase runs with no idling.
    for (int k = 0; k < 4; k++) begin
      program_registers(7'($urandom_range(0, 127)),
                        (k == 0) ? 16'd1 : 16'($urandom_range(0, 40)));
      if (k == 3) idling_on = 1'b0;
      queue_random_traffic(50);
      settle_to_idle();
    end

    repeat (5) @(posedge clk);
    if (mismatch_count == 0 && expected_levels.size() == 0) begin
      $display("i2c_eeprom_byte_master test passed");
    end else begin
      $display("i2c_eeprom_byte_master test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("i2c_eeprom_byte_master test failed");
    $finish;
  end

endmodule

FILE: files.f
design/i2cebm_pkg.sv
design/i2cebm_if.sv
design/i2c_eeprom_byte_master.sv
tb/tb_i2c_eeprom_byte_master.sv
